// ===== rtl/tdb_pkg.sv =====
`default_nettype none

package tdb_pkg;

  localparam int unsigned CHANNELS_DEF = 24;
  localparam int unsigned IN_CHANNELS  = 24;
  localparam int unsigned WORD_W       = 24;
  localparam int unsigned TIMER_W      = 8;
  localparam int unsigned ELAPSED_W    = 16;

  localparam logic [TIMER_W-1:0] TIMER_IDLE   = 8'hFF;
  localparam logic [TIMER_W-1:0] FILTER_RESET = 8'd20;
  localparam logic [TIMER_W-1:0] FILTER_MAX   = 8'd254;

  typedef struct packed {
    logic               en;
    logic               big;
    logic [TIMER_W-1:0] el_lo;
    logic [TIMER_W-1:0] filt;
  } tdb_tick_t;

  // reverse bit order, then invert (active-low inputs)
  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] b;
    b = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
    b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
    b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
    return ~b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdb_chan.sv =====
`default_nettype none

module tdb_chan
  import tdb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tdb_tick_t tick,
  input  wire logic      cur,
  output logic           deb_nxt,
  output logic           settle
);

  logic               last_r;
  logic               deb_r;
  logic [TIMER_W-1:0] timer_r;
  logic               last_nxt;
  logic [TIMER_W-1:0] timer_nxt;
  logic [TIMER_W:0]   sum;

  assign sum = {1'b0, tick.el_lo} + {1'b0, timer_r};

  always_comb begin
    last_nxt  = last_r;
    timer_nxt = timer_r;
    deb_nxt   = deb_r;
    settle    = 1'b0;
    if (tick.en) begin
      if (cur != last_r) begin
        last_nxt  = cur;
        timer_nxt = (deb_r == cur) ? TIMER_IDLE : '0;
      end else if (timer_r != TIMER_IDLE) begin
        if (tick.big || (sum > {1'b0, tick.filt})) begin
          timer_nxt = TIMER_IDLE;
          deb_nxt   = cur;
          settle    = 1'b1;
        end else begin
          timer_nxt = sum[TIMER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      deb_r   <= 1'b0;
      timer_r <= TIMER_IDLE;
    end else begin
      last_r  <= last_nxt;
      deb_r   <= deb_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/timed_debounce_24_inputs.sv =====
`default_nettype none

// Throughput: one word per cycle while the output is not stalled; all channel
// filters update in parallel in the single stage between the input register
// and the output register, which holds each accepted word's result.
// Reset (synchronous, active low): debounced and last-sample bits clear,
// every settle timer goes idle, filter time returns to 20 ms.
module timed_debounce_24_inputs
  import tdb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // expander_a, expander_b_high, elapsed_ms
  input  wire logic        in_tuser,   // force_report
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // debounced_word
  output logic [1:0]       out_tuser,  // changed, report
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata   // filter_ms
);

  logic [TIMER_W-1:0]   filter_r;
  logic                 in_vld_r;
  logic [39:0]          in_data_r;
  logic                 in_force_r;
  logic                 adv;
  logic [TIMER_W-1:0]   filt;
  logic [ELAPSED_W-1:0] elapsed;
  logic [WORD_W-1:0]    cur24;
  tdb_tick_t            tick;
  logic [CHANNELS-1:0]  deb_nxt;
  logic [CHANNELS-1:0]  settle;
  logic [WORD_W-1:0]    word_nxt;
  logic                 changed;

  assign adv       = in_vld_r && (!out_tvalid || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= FILTER_RESET;
    end else if (cfg_we) begin
      filter_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r  <= in_tdata;
      in_force_r <= in_tuser;
    end
  end

  assign filt    = (filter_r == TIMER_IDLE) ? FILTER_MAX : filter_r;
  assign elapsed = in_data_r[39:24];
  assign cur24   = {flip_byte(in_data_r[15:8]), flip_byte(in_data_r[7:0]),
                    flip_byte(in_data_r[23:16])};

  assign tick.en    = adv;
  assign tick.big   = elapsed >= {{(ELAPSED_W-TIMER_W){1'b0}}, filt};
  assign tick.el_lo = elapsed[TIMER_W-1:0];
  assign tick.filt  = filt;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    logic cur;
    if (ch < IN_CHANNELS) begin : g_in
      assign cur = cur24[ch];
    end else begin : g_zero
      assign cur = 1'b0;
    end
    tdb_chan u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (tick),
      .cur     (cur),
      .deb_nxt (deb_nxt[ch]),
      .settle  (settle[ch])
    );
  end

  for (genvar i = 0; i < WORD_W; i++) begin : g_word
    if (i < CHANNELS) begin : g_bit
      assign word_nxt[i] = deb_nxt[i];
    end else begin : g_pad
      assign word_nxt[i] = 1'b0;
    end
  end

  assign changed = |settle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= word_nxt;
      out_tuser <= {changed || in_force_r, changed};
    end
  end

`ifndef ASSERT_OFF
  a_changed_reports: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("changed without report");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word moved while stalled");

  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("result register not loaded");

  a_settle_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    |settle |-> adv)
    else $error("settle outside an accepted word");
`endif

endmodule

`default_nettype wire

// ===== sim/timed_debounce_24_inputs_tb.sv =====
`default_nettype none

module timed_debounce_24_inputs_tb;
  import tdb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIR     = 22;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 179;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              chg;
    logic              rpt;
  } deb_result_t;

  typedef struct packed {
    logic [15:0]       a;
    logic [7:0]        bh;
    logic [15:0]       el;
    logic              frc;
    logic              chk;
    logic [WORD_W-1:0] word;
    logic              chg;
    logic              rpt;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // expander_a, expander_b_high, elapsed_ms
  logic        in_tuser;   // force_report
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // debounced_word
  logic [1:0]  out_tuser;  // changed, report
  logic        cfg_we;
  logic [7:0]  cfg_wdata;  // filter_ms

  timed_debounce_24_inputs u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state
  logic [WORD_W-1:0]  deb_bits;
  logic [WORD_W-1:0]  last_bits;
  logic [TIMER_W-1:0] settle_tmr [WORD_W];
  logic [TIMER_W-1:0] filter_val;

  deb_result_t predicted_q [$];
  int          err_cnt;
  int          rx_count;
  logic        tx_idle;
  logic        rx_idle;

  stim_row_t dir_rows [NUM_DIR] = '{
    '{16'hFFFF, 8'hFF, 16'd5,     1'b0, 1'b1, 24'h000000, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd5,     1'b1, 1'b1, 24'h000000, 1'b0, 1'b1},
    '{16'h0000, 8'h00, 16'd0,     1'b0, 1'b1, 24'h000000, 1'b0, 1'b0},
    '{16'h0000, 8'h00, 16'hFFFF,  1'b0, 1'b1, 24'hFFFFFF, 1'b1, 1'b1},
    '{16'h0000, 8'h00, 16'hFFFF,  1'b1, 1'b1, 24'hFFFFFF, 1'b0, 1'b1},
    '{16'hFFFF, 8'hFF, 16'd0,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd19,    1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd1,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd1,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFE, 8'hFF, 16'd0,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd3,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'hFF, 16'd100,   1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'h7F, 16'd0,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hFFFF, 8'h7F, 16'h0100,  1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'h7FFF, 8'hFF, 16'd0,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'h7FFF, 8'hFF, 16'd15,    1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'h7FFF, 8'hFF, 16'd15,    1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'h5555, 8'hAA, 16'd0,     1'b1, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'h5555, 8'hAA, 16'd21,    1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hAAAA, 8'h55, 16'd0,     1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hAAAA, 8'h55, 16'd20,    1'b0, 1'b0, 24'h0, 1'b0, 1'b0},
    '{16'hAAAA, 8'h55, 16'd0,     1'b1, 1'b0, 24'h0, 1'b0, 1'b0}
  };

  logic [7:0] phase_filter [NUM_PHASES] = '{8'd1, 8'd254, 8'd0, 8'd255,
                                            8'd20, 8'd7, 8'd133, 8'd60};

  function automatic logic [7:0] mirror_invert(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = ~v[7-i];
    return r;
  endfunction

  function automatic int eff_filter();
    return (filter_val > FILTER_MAX) ? int'(FILTER_MAX) : int'(filter_val);
  endfunction

  function automatic deb_result_t debounce_sample(input logic [15:0] a,
                                                  input logic [7:0] bh,
                                                  input logic [15:0] el,
                                                  input logic frc);
    deb_result_t       r;
    logic [WORD_W-1:0] cur;
    int                filt;
    int                sum;
    logic              big;
    logic              chg;
    filt = eff_filter();
    big  = int'(el) >= filt;
    chg  = 1'b0;
    cur  = {mirror_invert(a[15:8]), mirror_invert(a[7:0]), mirror_invert(bh)};
    for (int ch = 0; ch < WORD_W; ch++) begin
      if (last_bits[ch] != cur[ch]) begin
        last_bits[ch]  = cur[ch];
        settle_tmr[ch] = (deb_bits[ch] == cur[ch]) ? TIMER_IDLE : '0;
      end else if (settle_tmr[ch] != TIMER_IDLE) begin
        sum = int'(el[7:0]) + int'(settle_tmr[ch]);
        if (big || sum > filt) begin
          settle_tmr[ch] = TIMER_IDLE;
          deb_bits[ch]   = cur[ch];
          chg            = 1'b1;
        end else begin
          settle_tmr[ch] = sum[TIMER_W-1:0];
        end
      end
    end
    r.word = deb_bits;
    r.chg  = chg;
    r.rpt  = chg | frc;
    return r;
  endfunction

  task automatic send_sample(input logic [15:0] a, input logic [7:0] bh,
                             input logic [15:0] el, input logic frc,
                             input logic chk, input deb_result_t typed);
    int          gap;
    deb_result_t r;
    gap = (tx_idle && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {el, bh, a};
    in_tuser  = frc;
    do @(posedge clk); while (!in_tready);
    r = debounce_sample(a, bh, el, frc);
    predicted_q.push_back(chk ? typed : r);
    @(negedge clk);
  endtask

  task automatic write_filter(input logic [7:0] v);
    in_tvalid = 1'b0;
    while (predicted_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we     = 1'b0;
    filter_val = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    deb_result_t exp_r;
    int          stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_count == HOLD_AT) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = (rx_idle && $urandom_range(0, 2) != 0) ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_count++;
      if (predicted_q.size() == 0) begin
        $display("%0t unexpected word: got %h/%b", $time, out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_r = predicted_q.pop_front();
        if (out_tdata !== exp_r.word) begin
          $display("%0t debounced_word: expected %h, got %h", $time, exp_r.word,
                   out_tdata);
          err_cnt++;
        end
        if (out_tuser[0] !== exp_r.chg) begin
          $display("%0t changed: expected %b, got %b", $time, exp_r.chg, out_tuser[0]);
          err_cnt++;
        end
        if (out_tuser[1] !== exp_r.rpt) begin
          $display("%0t report: expected %b, got %b", $time, exp_r.rpt, out_tuser[1]);
          err_cnt++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] raw_a;
    logic [7:0]  raw_bh;
    logic [15:0] el;
    int          sel;
    int          filt;
    int          n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    err_cnt    = 0;
    rx_count   = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    deb_bits   = '0;
    last_bits  = '0;
    filter_val = FILTER_RESET;
    for (int ch = 0; ch < WORD_W; ch++) settle_tmr[ch] = TIMER_IDLE;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_sample(dir_rows[i].a, dir_rows[i].bh, dir_rows[i].el, dir_rows[i].frc,
                  dir_rows[i].chk,
                  '{word: dir_rows[i].word, chg: dir_rows[i].chg, rpt: dir_rows[i].rpt});

    raw_a  = 16'hFFFF;
    raw_bh = 8'hFF;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_filter(phase_filter[p]);
      tx_idle = (p != 4);
      rx_idle = (p != 4);
      filt = eff_filter();
      for (int k = 0; k < PHASE_WORDS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel >= 60 && sel < 88) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            sel = $urandom_range(0, 23);
            if (sel < 8) raw_bh[sel] = ~raw_bh[sel];
            else raw_a[sel-8] = ~raw_a[sel-8];
          end
        end else if (sel >= 88) begin
          raw_a  = 16'($urandom_range(0, 16'hFFFF));
          raw_bh = 8'($urandom_range(0, 8'hFF));
        end
        sel = $urandom_range(0, 99);
        if (sel < 50) el = 16'($urandom_range(0, filt / 4 + 1));
        else if (sel < 78) el = 16'($urandom_range(0, 300));
        else if (sel < 90) el = 16'($urandom_range(0, 16'hFFFF));
        else if (sel < 97) el = 16'(filt + $urandom_range(0, 2)) - 16'd1;
        else el = 16'h0100 | 16'($urandom_range(0, 255));
        send_sample(raw_a, raw_bh, el, $urandom_range(0, 3) == 0, 1'b0, '0);
      end
    end
    in_tvalid = 1'b0;

    while (predicted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
